// File: rtl/tafir_pkg.sv
// Shared constants and types for the three-axis FIR filter.
`default_nettype none

package tafir_pkg;

  localparam int TAPS        = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int NCOEF       = 8;
  localparam int COEF_BITS   = 18;
  localparam int COEF_FRAC   = 16;
  localparam int DIGIT_BITS  = 4;
  localparam int NDIGITS     = SAMPLE_BITS / DIGIT_BITS;

  localparam int TAP_W       = $clog2(TAPS);
  localparam int DIG_W       = (NDIGITS > 1) ? $clog2(NDIGITS) : 1;
  localparam int COEF_IDX_W  = $clog2(NCOEF);
  localparam int CFG_IDX_W   = COEF_IDX_W + 1;

  localparam int PROD_W      = COEF_BITS + DIGIT_BITS + 1;
  localparam int P_W         = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_W       = P_W + TAP_W;

  // Unity gain in Q1.16, the reset value of the newest-sample weight.
  localparam logic signed [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(1 << COEF_FRAC);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // Sequencer controls shared by the three axis datapaths.
  typedef struct packed {
    logic             shift;  // accepted sample enters the tap line
    logic             clear;  // restart the accumulator
    logic             run;    // one digit step this cycle
    logic             first;  // most significant digit of a tap
    logic             last;   // least significant digit of a tap
    logic [TAP_W-1:0] tap;    // tap being multiplied
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/three_axis_fir_filter.sv
// Top level of the three-axis accelerometer FIR filter.
// A new sample is taken only once the last result has moved to the output register, as
// each axis has a single 4-bit digit multiplier, which walks 8 taps of 4 digits each.
// Reset clears the tap delay lines and sets the newest-sample weight to unity, others zero.
// Configuration writes take effect at the clock edge of the write.
`default_nettype none

module three_axis_fir_filter (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [tafir_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire  [tafir_pkg::COEF_BITS-1:0]       cfg_data_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  signed [tafir_pkg::SAMPLE_BITS-1:0] accel_x_i,
  input  wire  signed [tafir_pkg::SAMPLE_BITS-1:0] accel_y_i,
  input  wire  signed [tafir_pkg::SAMPLE_BITS-1:0] accel_z_i,
  input  wire                                   block_end_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic signed [tafir_pkg::SAMPLE_BITS-1:0] filtered_x_o,
  output logic signed [tafir_pkg::SAMPLE_BITS-1:0] filtered_y_o,
  output logic signed [tafir_pkg::SAMPLE_BITS-1:0] filtered_z_o,
  output logic                                  block_end_out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [tafir_pkg::TAP_W-1:0]     tap_q;
  logic [tafir_pkg::DIG_W-1:0]     dig_q;
  logic                            out_valid_q;
  logic                            block_end_q;
  tafir_pkg::coef_t                coef_q [tafir_pkg::NCOEF];
  tafir_pkg::coef_t                coef_sel;
  tafir_pkg::ctl_t                 ctl;
  tafir_pkg::sample_t              res_x, res_y, res_z;
  logic                            accept;
  logic                            dig_last;
  logic                            tap_last;
  logic                            load_out;

  // The sequencer walks the taps oldest first. Within a tap the sample is
  // fed most significant digit first, so the top digit carries the sign.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = in_valid_i & ~in_stall_o;
    dig_last   = (dig_q == tafir_pkg::DIG_W'(tafir_pkg::NDIGITS - 1));
    tap_last   = (tap_q == tafir_pkg::TAP_W'(tafir_pkg::TAPS - 1));
    // The finished sum moves to the output register once that register is
    // empty or its current result is being transferred out.
    load_out   = (state_q == ST_DONE) & (~out_valid_q | ~out_stall_i);
    ctl.shift  = accept;
    ctl.clear  = accept;
    ctl.run    = (state_q == ST_RUN);
    ctl.first  = (dig_q == '0);
    ctl.last   = dig_last;
    ctl.tap    = tap_q;
    // With fewer taps than weight registers, the leading weights are unused.
    coef_sel   = coef_q[tafir_pkg::COEF_IDX_W'(tafir_pkg::NCOEF - tafir_pkg::TAPS)
                        + tafir_pkg::COEF_IDX_W'(tap_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
            tap_q   <= '0;
            dig_q   <= '0;
          end
        end
        ST_RUN: begin
          if (dig_last) begin
            dig_q <= '0;
            if (tap_last) begin
              state_q <= ST_DONE;
            end else begin
              tap_q <= tap_q + 1'b1;
            end
          end else begin
            dig_q <= dig_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Tap weights. A write to an index past the last weight is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tafir_pkg::NCOEF - 1; k++) begin
        coef_q[k] <= '0;
      end
      coef_q[tafir_pkg::NCOEF-1] <= tafir_pkg::COEF_UNITY;
    end else if (cfg_we_i && (cfg_idx_i < tafir_pkg::CFG_IDX_W'(tafir_pkg::NCOEF))) begin
      coef_q[cfg_idx_i[tafir_pkg::COEF_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // Output payload and the block marker, which passes through untouched.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      block_end_q <= block_end_i;
    end
    if (load_out) begin
      filtered_x_o    <= res_x;
      filtered_y_o    <= res_y;
      filtered_z_o    <= res_z;
      block_end_out_o <= block_end_q;
    end
  end

  assign out_valid_o = out_valid_q;

  tafir_mac u_mac_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (accel_x_i),
    .coef_i   (coef_sel),
    .result_o (res_x)
  );

  tafir_mac u_mac_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (accel_y_i),
    .coef_i   (coef_sel),
    .result_o (res_y)
  );

  tafir_mac u_mac_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .sample_i (accel_z_i),
    .coef_i   (coef_sel),
    .result_o (res_z)
  );

endmodule

`default_nettype wire

// File: rtl/tafir_mac.sv
// One axis: tap delay line and digit-serial multiply-accumulate.
`default_nettype none

module tafir_mac (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire tafir_pkg::ctl_t    ctl_i,
  input  wire tafir_pkg::sample_t sample_i,
  input  wire tafir_pkg::coef_t   coef_i,
  output tafir_pkg::sample_t   result_o
);

  localparam int RW = tafir_pkg::ACC_W - tafir_pkg::COEF_FRAC;
  localparam logic signed [RW-1:0] RMax = RW'((1 << (tafir_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] RMin = -RW'(1 << (tafir_pkg::SAMPLE_BITS - 1));
  localparam logic [tafir_pkg::ACC_W-1:0] RoundHalf =
    tafir_pkg::ACC_W'(1 << (tafir_pkg::COEF_FRAC - 1));

  tafir_pkg::sample_t taps_q [tafir_pkg::TAPS];
  tafir_pkg::sample_t dsr_q, dsr_d, src;
  logic [tafir_pkg::DIGIT_BITS-1:0]              digit;
  logic signed [tafir_pkg::DIGIT_BITS:0]         sdig;
  logic signed [tafir_pkg::PROD_W-1:0]           prod;
  logic signed [tafir_pkg::P_W-1:0]              p_q, p_d, p_shift;
  logic signed [tafir_pkg::ACC_W-1:0]            acc_q, acc_d;
  logic [tafir_pkg::ACC_W-1:0]                   rnd;
  logic signed [RW-1:0]                          r;

  // The digit shift register is loaded straight from the tap line on the
  // first digit, so a tap needs no separate load cycle.
  always_comb begin
    src     = ctl_i.first ? taps_q[ctl_i.tap] : dsr_q;
    digit   = src[tafir_pkg::SAMPLE_BITS-1 -: tafir_pkg::DIGIT_BITS];
    dsr_d   = src << tafir_pkg::DIGIT_BITS;
    sdig    = {(ctl_i.first & digit[tafir_pkg::DIGIT_BITS-1]), digit};
    prod    = coef_i * sdig;
    p_shift = {p_q[tafir_pkg::P_W-tafir_pkg::DIGIT_BITS-1:0],
               {tafir_pkg::DIGIT_BITS{1'b0}}};
    p_d     = (ctl_i.first ? '0 : p_shift) + tafir_pkg::P_W'(prod);
    acc_d   = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.run && ctl_i.last) begin
      acc_d = acc_q + tafir_pkg::ACC_W'(p_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tafir_pkg::TAPS; k++) begin
        taps_q[k] <= '0;
      end
    end else if (ctl_i.shift) begin
      for (int k = 0; k < tafir_pkg::TAPS - 1; k++) begin
        taps_q[k] <= taps_q[k+1];
      end
      taps_q[tafir_pkg::TAPS-1] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctl_i.run) begin
      dsr_q <= dsr_d;
      p_q   <= p_d;
    end
  end

  // Round half up, drop the coefficient fraction, then clamp.
  always_comb begin
    rnd = acc_q + RoundHalf;
    r   = rnd[tafir_pkg::ACC_W-1:tafir_pkg::COEF_FRAC];
    if (r > RMax) begin
      result_o = RMax[tafir_pkg::SAMPLE_BITS-1:0];
    end else if (r < RMin) begin
      result_o = RMin[tafir_pkg::SAMPLE_BITS-1:0];
    end else begin
      result_o = r[tafir_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: verif/fir_result_checker.sv
// Checker that predicts the filtered accelerometer samples and compares the results.
`timescale 1ns / 100ps

module fir_result_checker (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [tafir_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [tafir_pkg::COEF_BITS-1:0]    cfg_data_i,
  input  wire                               in_valid_i,
  input  wire                               in_stall_i,
  input  tafir_pkg::sample_t                accel_x_i,
  input  tafir_pkg::sample_t                accel_y_i,
  input  tafir_pkg::sample_t                accel_z_i,
  input  wire                               block_end_i,
  input  wire                               out_valid_i,
  input  wire                               out_stall_i,
  input  tafir_pkg::sample_t                filtered_x_i,
  input  tafir_pkg::sample_t                filtered_y_i,
  input  tafir_pkg::sample_t                filtered_z_i,
  input  wire                               block_end_out_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                results_o
);

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;
  localparam int NAXES  = 3;

  localparam longint ROUND_HALF = longint'(1) << (tafir_pkg::COEF_FRAC - 1);
  localparam longint OUT_MAX    = (longint'(1) << (tafir_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint OUT_MIN    = -(longint'(1) << (tafir_pkg::SAMPLE_BITS - 1));

  typedef struct packed {
    tafir_pkg::sample_t x;
    tafir_pkg::sample_t y;
    tafir_pkg::sample_t z;
    logic               blk;
  } filt_sample_t;

  tafir_pkg::coef_t   tap_weight [tafir_pkg::NCOEF];
  tafir_pkg::sample_t delay_line [NAXES][tafir_pkg::TAPS-1];
  filt_sample_t       expected_filt_q [$];
  int                 fail_count   = 0;
  int                 result_count = 0;

  // One axis of the filter: full-precision sum over the taps, then the new
  // sample enters the delay line, then round half up and saturate.
  function automatic tafir_pkg::sample_t filter_axis(int axis, tafir_pkg::sample_t s);
    longint acc;
    longint r;
    int     k;
    acc = longint'(s) * longint'(tap_weight[tafir_pkg::NCOEF-1]);
    for (k = 0; k < tafir_pkg::TAPS - 1; k++) begin
      acc += longint'(delay_line[axis][k])
             * longint'(tap_weight[tafir_pkg::NCOEF-tafir_pkg::TAPS+k]);
    end
    for (k = 0; k < tafir_pkg::TAPS - 2; k++) begin
      delay_line[axis][k] = delay_line[axis][k+1];
    end
    delay_line[axis][tafir_pkg::TAPS-2] = s;
    r = (acc + ROUND_HALF) >>> tafir_pkg::COEF_FRAC;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end else if (r < OUT_MIN) begin
      r = OUT_MIN;
    end
    return tafir_pkg::sample_t'(r);
  endfunction

  function automatic void check_field(string name, tafir_pkg::sample_t want,
                                      tafir_pkg::sample_t got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filt_sample_t want;
    int           a;
    int           k;
    if (!rst_ni) begin
      for (k = 0; k < tafir_pkg::NCOEF; k++) begin
        tap_weight[k] = (k == tafir_pkg::NCOEF - 1) ? tafir_pkg::COEF_UNITY : '0;
      end
      for (a = 0; a < NAXES; a++) begin
        for (k = 0; k < tafir_pkg::TAPS - 1; k++) begin
          delay_line[a][k] = '0;
        end
      end
      expected_filt_q.delete();
    end else begin
      if (cfg_we_i && cfg_idx_i < tafir_pkg::NCOEF) begin
        tap_weight[cfg_idx_i[tafir_pkg::COEF_IDX_W-1:0]] = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        want.x   = filter_axis(AXIS_X, accel_x_i);
        want.y   = filter_axis(AXIS_Y, accel_y_i);
        want.z   = filter_axis(AXIS_Z, accel_z_i);
        want.blk = block_end_i;
        expected_filt_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        result_count++;
        if (expected_filt_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, got x=%0d y=%0d z=%0d end=%0b",
                   $time, filtered_x_i, filtered_y_i, filtered_z_i, block_end_out_i);
        end else begin
          want = expected_filt_q.pop_front();
          check_field("filtered_x", want.x, filtered_x_i);
          check_field("filtered_y", want.y, filtered_y_i);
          check_field("filtered_z", want.z, filtered_z_i);
          check_field("block_end_out", tafir_pkg::sample_t'(want.blk),
                      tafir_pkg::sample_t'(block_end_out_i));
        end
      end
    end
    // Counters go out registered so the stimulus side reads them without a race.
    fail_count_o <= fail_count;
    pending_o    <= expected_filt_q.size();
    results_o    <= result_count;
  end

endmodule

// File: verif/tb_three_axis_fir_filter.sv
// Testbench top for the three-axis FIR filter: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_three_axis_fir_filter;

  localparam int CLK_HALF           = 10;
  localparam int RESET_CYCLES       = 11;
  // Sets how long stray results are watched for after the last expected one.
  localparam int LATENCY            = tafir_pkg::TAPS * tafir_pkg::NDIGITS + 2;
  localparam int CYCLE_LIMIT        = 2_000_000;
  localparam int RANDOM_PHASES      = 10;
  localparam int SAMPLES_PER_PHASE  = 165;
  localparam int HOLD_AFTER_RESULTS = 300;
  localparam int HOLD_CYCLES        = 400;
  localparam int MAX_BLOCK_LEN      = 16;

  localparam int CIW = tafir_pkg::CFG_IDX_W;
  localparam int CBW = tafir_pkg::COEF_BITS;
  localparam int SBW = tafir_pkg::SAMPLE_BITS;

  localparam logic [CIW-1:0] IDX_UNMAPPED_LO = CIW'(tafir_pkg::NCOEF);
  localparam logic [CIW-1:0] IDX_UNMAPPED_HI = '1;

  localparam tafir_pkg::coef_t   COEF_MAX   = {1'b0, {(CBW-1){1'b1}}};
  localparam tafir_pkg::coef_t   COEF_MIN   = {1'b1, {(CBW-1){1'b0}}};
  // Half of one output step: odd samples times this weight land exactly on ties.
  localparam tafir_pkg::coef_t   COEF_TIE   =
    tafir_pkg::coef_t'(1 << (tafir_pkg::COEF_FRAC - 1));
  localparam tafir_pkg::sample_t SAMPLE_MAX = {1'b0, {(SBW-1){1'b1}}};
  localparam tafir_pkg::sample_t SAMPLE_MIN = {1'b1, {(SBW-1){1'b0}}};

  typedef enum int {
    SET_RANDOM,
    SET_AVERAGE,
    SET_MAX_ALL,
    SET_MIN_ALL,
    SET_SHORT,
    SET_SMALL,
    NUM_SET_KINDS
  } coef_kind_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CIW-1:0]       cfg_idx_i   = '0;
  tafir_pkg::coef_t     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  tafir_pkg::sample_t   accel_x_i   = '0;
  tafir_pkg::sample_t   accel_y_i   = '0;
  tafir_pkg::sample_t   accel_z_i   = '0;
  logic                 block_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  tafir_pkg::sample_t   filtered_x_o;
  tafir_pkg::sample_t   filtered_y_o;
  tafir_pkg::sample_t   filtered_z_o;
  logic                 block_end_out_o;

  int               fail_count;
  int               pending;
  int               results_seen;
  int               samples_sent    = 0;
  int               block_ends_sent = 0;
  int               settings_loaded = 0;
  int               cycle_count     = 0;
  bit               hold_done       = 1'b0;
  tafir_pkg::coef_t coef_set [tafir_pkg::NCOEF];

  three_axis_fir_filter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .block_end_i     (block_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_x_o    (filtered_x_o),
    .filtered_y_o    (filtered_y_o),
    .filtered_z_o    (filtered_z_o),
    .block_end_out_o (block_end_out_o)
  );

  fir_result_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .block_end_i     (block_end_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_x_i    (filtered_x_o),
    .filtered_y_i    (filtered_y_o),
    .filtered_z_i    (filtered_z_o),
    .block_end_out_i (block_end_out_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (results_seen)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Watchdog: a run that is still going at the cycle limit has hung.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
    $display("TEST FAILED");
    $finish;
  end

  // Gap lengths for both sides: mostly none or short, now and then a long one
  // so that idle stretches fall on every point of the block's digit schedule.
  function automatic int pick_gap();
    int roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 90);
  endfunction

  // Mix of full-scale noise, gentle motion near zero, about one g, and the rails.
  function automatic tafir_pkg::sample_t rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return tafir_pkg::sample_t'($urandom);
      5, 6:          return tafir_pkg::sample_t'(int'($urandom_range(0, 1024)) - 512);
      7:             return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      8:             return tafir_pkg::sample_t'(int'($urandom_range(0, 4)) - 2);
      default:       return tafir_pkg::sample_t'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic void fill_coef_set(coef_kind_e kind);
    int k;
    int lead;
    lead = $urandom_range(1, tafir_pkg::NCOEF - 2);
    for (k = 0; k < tafir_pkg::NCOEF; k++) begin
      case (kind)
        SET_RANDOM:  coef_set[k] = tafir_pkg::coef_t'($urandom);
        SET_AVERAGE: coef_set[k] =
          tafir_pkg::coef_t'((1 << tafir_pkg::COEF_FRAC) / tafir_pkg::NCOEF);
        SET_MAX_ALL: coef_set[k] = COEF_MAX;
        SET_MIN_ALL: coef_set[k] = COEF_MIN;
        // A shorter filter: the oldest taps carry zero weight.
        SET_SHORT:   coef_set[k] = (k < lead) ? '0 : tafir_pkg::coef_t'($urandom);
        default:     coef_set[k] = tafir_pkg::coef_t'(int'($urandom_range(0, 8192)) - 4096);
      endcase
    end
  endfunction

  // One register write per clock. The write enable stays high across a burst
  // and drops in the cycle after the last write.
  task automatic write_reg(logic [CIW-1:0] idx, tafir_pkg::coef_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Writes the whole weight set, preceded by writes to unmapped indexes that
  // the block has to ignore.
  task automatic load_coef_set(int unmapped_writes);
    int k;
    repeat (unmapped_writes) begin
      write_reg(CIW'($urandom_range(IDX_UNMAPPED_LO, IDX_UNMAPPED_HI)),
                tafir_pkg::coef_t'($urandom));
    end
    for (k = 0; k < tafir_pkg::NCOEF; k++) begin
      write_reg(CIW'(k), coef_set[k]);
    end
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // Offers one sample and holds it until the transfer happens, then maybe idles.
  // With no gap the valid simply stays high for the next sample.
  task automatic send_sample(tafir_pkg::sample_t x, tafir_pkg::sample_t y,
                             tafir_pkg::sample_t z, logic blk);
    int gap;
    in_valid_i  <= 1'b1;
    accel_x_i   <= x;
    accel_y_i   <= y;
    accel_z_i   <= z;
    block_end_i <= blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
    if (blk) block_ends_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits for every outstanding result. The pending count
  // is registered and lags the clock, so it never reads zero too early.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Output side: free stretches of varying length, short or long stalls, and
  // once the run is well under way a single long hold-off. During that hold the
  // sender keeps going, so the block fills up and has to stall its input.
  initial begin : receiver
    int free_len;
    int stall_len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      out_stall_i <= 1'b0;
      free_len = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
      repeat (free_len) @(posedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
        stall_len = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int         phase;
    int         block_left;
    int         k;
    logic       blk;
    coef_kind_e kind;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Weights straight out of reset: the newest tap has unity gain and all the
    // others are zero, so every sample must come through unchanged.
    send_sample(SAMPLE_MAX, SAMPLE_MIN, '0, 1'b1);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, tafir_pkg::sample_t'(-1), 1'b0);
    send_sample(tafir_pkg::sample_t'(1), tafir_pkg::sample_t'(-1), SAMPLE_MAX, 1'b1);
    send_sample(tafir_pkg::sample_t'(-2), tafir_pkg::sample_t'(4096), SAMPLE_MIN, 1'b0);
    wait_drained();

    // Largest positive weight on every tap drives the sums far past both rails.
    fill_coef_set(SET_MAX_ALL);
    load_coef_set(2);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, '0, 1'b1);
    wait_drained();

    // Most negative weight everywhere: negative full-scale input saturates high.
    fill_coef_set(SET_MIN_ALL);
    load_coef_set(1);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    wait_drained();

    // Half-step weight on the newest tap only: odd samples hit exact ties,
    // which must round toward plus infinity for both signs.
    for (k = 0; k < tafir_pkg::NCOEF - 1; k++) begin
      coef_set[k] = '0;
    end
    coef_set[tafir_pkg::NCOEF-1] = COEF_TIE;
    load_coef_set(1);
    send_sample(tafir_pkg::sample_t'(1), tafir_pkg::sample_t'(-1),
                tafir_pkg::sample_t'(3), 1'b0);
    send_sample(tafir_pkg::sample_t'(-3), SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    wait_drained();

    // Shortened filter with the oldest half of the taps zeroed.
    for (k = 0; k < tafir_pkg::NCOEF; k++) begin
      coef_set[k] = (k < tafir_pkg::NCOEF / 2) ? '0 : tafir_pkg::coef_t'($urandom);
    end
    load_coef_set(2);
    send_sample(rand_sample(), rand_sample(), rand_sample(), 1'b0);
    send_sample(rand_sample(), rand_sample(), rand_sample(), 1'b1);
    send_sample(rand_sample(), rand_sample(), rand_sample(), 1'b0);
    wait_drained();

    // Random part: each phase loads a new weight set while the block is idle,
    // then streams software blocks of random length. Now and then a marker is
    // dropped or a stray one appears, and the sender sometimes pauses until
    // every result is back.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = coef_kind_e'(phase % NUM_SET_KINDS);
      fill_coef_set(kind);
      load_coef_set($urandom_range(1, 2));
      block_left = $urandom_range(1, MAX_BLOCK_LEN);
      repeat (SAMPLES_PER_PHASE) begin
        block_left--;
        blk = (block_left == 0);
        if ($urandom_range(0, 19) == 0) blk = ~blk;
        if (block_left == 0) block_left = $urandom_range(1, MAX_BLOCK_LEN);
        send_sample(rand_sample(), rand_sample(), rand_sample(), blk);
        if ($urandom_range(0, 79) == 0) wait_drained();
      end
      wait_drained();
    end

    // Give the block time to show any result that nobody asked for.
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("Run: %0d samples (%0d block ends) over %0d weight settings, %0d results checked.",
             samples_sent, block_ends_sent, settings_loaded, results_seen);
    $display("Saturation, tie rounding, shortened filters and a %0d-cycle output hold (%0s).",
             HOLD_CYCLES, hold_done ? "done" : "not reached");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tafir_pkg.sv
rtl/tafir_mac.sv
rtl/three_axis_fir_filter.sv
verif/fir_result_checker.sv
verif/tb_three_axis_fir_filter.sv
